// ===== design/scfr_pkg.sv =====
// ---------------------------------------------------------------------------
// scfr_pkg - shared types and constants of the second-chance frame replacer
// Operation and status codes, frame attribute entry, result item and the
// write-back rule for a page that leaves its frame.
// ---------------------------------------------------------------------------
package scfr_pkg;

  localparam int NUM_FRAMES_DEF = 64;
  localparam int FM_WORD        = 64;   // bits per word of the free map
  localparam int FRAME_W        = 6;    // width of the frame fields
  localparam logic [3:0] MAX_PASSES_RST = 4'd6;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_REF     = 3'd1,
    OP_PIN     = 3'd2,
    OP_UNPIN   = 3'd3,
    OP_RELEASE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_VICTIM = 2'd1,
    ST_BAD_FRAME = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WB_DISCARD = 2'd0,
    WB_FILE    = 2'd1,
    WB_SWAP    = 2'd2
  } wb_t;

  // origin bits of a resident page
  localparam int ORG_LOADED = 0;
  localparam int ORG_MMAP   = 1;
  localparam int ORG_MOD    = 2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TGT,
    S_FREE,
    S_SWEEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] origin;
    logic       dirty;
    logic       refd;
    logic       pinned;
    logic       valid;
  } attr_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [FRAME_W-1:0] frame;
    logic               is_write;
    logic [2:0]         origin;
  } item_t;

  typedef struct packed {
    logic               page_modified;
    logic [1:0]         writeback;
    logic               writeback_valid;
    logic [1:0]         status;
    logic               evicted;
    logic [FRAME_W-1:0] frame_out;
  } res_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic set;
  } fm_cmd_t;

  typedef struct packed {
    logic [1:0] wb;
    logic       modified;
  } wb_info_t;

  function automatic wb_info_t leave_page(input attr_t a);
    wb_info_t w;
    logic     m;
    m = a.dirty | a.origin[ORG_MOD];
    if (a.origin[ORG_LOADED] && !m) begin
      w.wb = WB_DISCARD;
    end else if (a.origin[ORG_MMAP]) begin
      w.wb = a.dirty ? WB_FILE : WB_DISCARD;
    end else begin
      w.wb = WB_SWAP;
    end
    w.modified = m;
    return w;
  endfunction

endpackage

// ===== design/scfr_free_map.sv =====
// ---------------------------------------------------------------------------
// scfr_free_map - occupancy bitmap of the frame pool
// One bit per frame in words of up to 64 bits. The word read last is
// searched for its lowest free frame; writes set, clear or wipe one word.
// ---------------------------------------------------------------------------
module scfr_free_map
  import scfr_pkg::*;
#(
  parameter  int NUM_FRAMES = NUM_FRAMES_DEF,
  localparam int WB         = (NUM_FRAMES < FM_WORD) ? NUM_FRAMES : FM_WORD,
  localparam int WBW        = $clog2(WB),
  localparam int NW         = (NUM_FRAMES + WB - 1) / WB,
  localparam int WIW        = (NW > 1) ? $clog2(NW) : 1
) (
  input  logic                clk,
  input  logic [WIW-1:0]      rd_addr,
  input  fm_cmd_t             cmd,
  input  logic [WIW-1:0]      wr_addr,
  input  logic [WBW-1:0]      wr_bit,
  output logic                free_any,
  output logic [WBW-1:0]      free_pos
);

  localparam int LASTB = NUM_FRAMES - (NW - 1) * WB;

  logic [WB-1:0]  mem [NW];
  logic [WB-1:0]  rd_word;
  logic [WIW-1:0] rd_waddr;
  logic [WB-1:0]  free_mask;
  logic [WB-1:0]  onehot;
  logic [WB-1:0]  new_word;
  logic           at_last;

  // set and clear modify the word read in the previous cycle; a wipe writes zeros
  assign onehot   = WB'(1) << wr_bit;
  assign new_word = cmd.clr ? '0 : (cmd.set ? (rd_word | onehot) : (rd_word & ~onehot));

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= new_word;
    end
    rd_word  <= mem[rd_addr];
    rd_waddr <= rd_addr;
  end

  assign at_last = (rd_waddr == WIW'(NW - 1));

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      free_mask[b] = !rd_word[b] && !(at_last && (b >= LASTB));
    end
  end

  // lowest free bit wins
  always_comb begin
    free_pos = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (free_mask[b]) free_pos = WBW'(b);
    end
  end

  assign free_any = |free_mask;

endmodule

// ===== design/scfr_ctrl.sv =====
// ---------------------------------------------------------------------------
// scfr_ctrl - sequencer and frame attribute memory
// Holds per-frame attributes in a synchronous memory, runs the clearing
// pass, the free-frame search, the clock sweep and the per-frame updates.
// ---------------------------------------------------------------------------
module scfr_ctrl
  import scfr_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] max_passes,
  input  logic       in_valid,
  input  item_t      in_item,
  output logic       in_ready,
  input  logic       out_free,
  output logic       res_push,
  output res_t       res
);

  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int WB  = (NUM_FRAMES < FM_WORD) ? NUM_FRAMES : FM_WORD;
  localparam int WBW = $clog2(WB);
  localparam int NW  = (NUM_FRAMES + WB - 1) / WB;
  localparam int WIW = (NW > 1) ? $clog2(NW) : 1;

  function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] p);
    return (p == FW'(NUM_FRAMES - 1)) ? '0 : p + 1'b1;
  endfunction

  state_t state, state_next;

  item_t          item;
  res_t           res_next;
  logic [FW-1:0]  hand, hand_next;
  logic [FW-1:0]  clr_idx, clr_next;
  logic [FW-1:0]  iss, iss_next;
  logic [FW-1:0]  evl, evl_next;
  logic [FW-1:0]  step_cnt, step_next;
  logic [3:0]     pass_cnt, pass_next;
  logic [WIW-1:0] widx, widx_next;

  // attribute memory
  attr_t         mem [NUM_FRAMES];
  attr_t         attr_rd;
  logic [FW-1:0] attr_raddr;
  logic          attr_we;
  logic [FW-1:0] attr_waddr;
  attr_t         attr_wdata;

  // free map
  logic [WIW-1:0] fm_raddr;
  fm_cmd_t        fm_cmd;
  logic [WIW-1:0] fm_waddr;
  logic [WBW-1:0] fm_wbit;
  logic           free_any;
  logic [WBW-1:0] free_pos;

  logic [FW+FRAME_W-1:0] in_ext, tg_ext;
  logic [FW-1:0]         in_addr, tg_addr, free_addr;
  logic                  tg_bad;
  logic                  fr_last;
  logic                  sw_live, sw_victim, sw_wrap, sw_end;
  logic [3:0]            pass_inc;
  wb_info_t              lv;
  attr_t                 fresh;

  scfr_free_map #(.NUM_FRAMES(NUM_FRAMES)) u_free_map (
    .clk      (clk),
    .rd_addr  (fm_raddr),
    .cmd      (fm_cmd),
    .wr_addr  (fm_waddr),
    .wr_bit   (fm_wbit),
    .free_any (free_any),
    .free_pos (free_pos)
  );

  always_ff @(posedge clk) begin
    if (attr_we) begin
      mem[attr_waddr] <= attr_wdata;
    end
    attr_rd <= mem[attr_raddr];
  end

  assign in_ext    = {{FW{1'b0}}, in_item.frame};
  assign in_addr   = in_ext[FW-1:0];
  assign tg_ext    = {{FW{1'b0}}, item.frame};
  assign tg_addr   = tg_ext[FW-1:0];
  assign tg_bad    = (tg_ext >= (FW + FRAME_W)'(NUM_FRAMES)) || !attr_rd.valid;
  assign free_addr = FW'({widx, free_pos});
  assign fr_last   = (widx == WIW'(NW - 1));
  assign fresh     = '{origin: item.origin, dirty: 1'b0, refd: 1'b0,
                       pinned: 1'b0, valid: 1'b1};

  assign sw_live   = attr_rd.valid && !attr_rd.pinned;
  assign sw_victim = sw_live && !attr_rd.refd;
  assign sw_wrap   = (step_cnt == FW'(NUM_FRAMES - 1));
  assign pass_inc  = pass_cnt + 4'd1;
  assign sw_end    = sw_wrap && (pass_inc == max_passes);
  assign lv        = leave_page(attr_rd);

  assign in_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      hand    <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_next;
      hand    <= hand_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    res      <= res_next;
    iss      <= iss_next;
    evl      <= evl_next;
    step_cnt <= step_next;
    pass_cnt <= pass_next;
    widx     <= widx_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == FW'(NUM_FRAMES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_item.op)
            OP_ALLOC:                               state_next = S_FREE;
            OP_REF, OP_PIN, OP_UNPIN, OP_RELEASE:   state_next = S_TGT;
            default:                                state_next = S_DONE;
          endcase
        end
      end
      S_TGT:   state_next = S_DONE;
      S_FREE: begin
        if (free_any || (fr_last && max_passes == 4'd0)) begin
          state_next = S_DONE;
        end else if (fr_last) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sw_victim || sw_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    attr_raddr = '0;
    attr_we    = 1'b0;
    attr_waddr = evl;
    attr_wdata = '0;
    fm_raddr   = '0;
    fm_cmd     = '0;
    fm_waddr   = '0;
    fm_wbit    = '0;
    res_next   = res;
    res_push   = 1'b0;
    hand_next  = hand;
    clr_next   = clr_idx;
    iss_next   = iss;
    evl_next   = evl;
    step_next  = step_cnt;
    pass_next  = pass_cnt;
    widx_next  = widx;
    case (state)
      S_CLEAR: begin
        attr_we    = 1'b1;
        attr_waddr = clr_idx;
        fm_cmd.wr  = ((FW + 1)'(clr_idx) < (FW + 1)'(NW));
        fm_cmd.clr = 1'b1;
        fm_waddr   = WIW'(clr_idx);
        clr_next   = clr_idx + 1'b1;
      end
      S_IDLE: begin
        attr_raddr = in_addr;
        fm_raddr   = (in_item.op == OP_ALLOC) ? '0 : WIW'(in_addr >> WBW);
        widx_next  = '0;
        res_next   = '0;
      end
      S_TGT: begin
        res_next.frame_out = item.frame;
        attr_waddr         = tg_addr;
        attr_wdata         = attr_rd;
        if (tg_bad) begin
          res_next.status = ST_BAD_FRAME;
        end else begin
          case (item.op)
            OP_REF: begin
              attr_we          = 1'b1;
              attr_wdata.refd  = 1'b1;
              attr_wdata.dirty = attr_rd.dirty | item.is_write;
            end
            OP_PIN: begin
              attr_we           = 1'b1;
              attr_wdata.pinned = 1'b1;
            end
            OP_UNPIN: begin
              attr_we           = 1'b1;
              attr_wdata.pinned = 1'b0;
            end
            OP_RELEASE: begin
              attr_we                  = 1'b1;
              attr_wdata               = '0;
              fm_cmd.wr                = 1'b1;
              fm_waddr                 = WIW'(tg_addr >> WBW);
              fm_wbit                  = tg_addr[WBW-1:0];
              res_next.writeback_valid = 1'b1;
              res_next.writeback       = lv.wb;
              res_next.page_modified   = lv.modified;
            end
            default: ;
          endcase
        end
      end
      S_FREE: begin
        if (free_any) begin
          attr_we            = 1'b1;
          attr_waddr         = free_addr;
          attr_wdata         = fresh;
          fm_cmd.wr          = 1'b1;
          fm_cmd.set         = 1'b1;
          fm_waddr           = widx;
          fm_wbit            = free_pos;
          res_next.frame_out = FRAME_W'(free_addr);
        end else if (fr_last) begin
          if (max_passes == 4'd0) begin
            res_next.status = ST_NO_VICTIM;
          end else begin
            // start the sweep at the hand
            attr_raddr = hand;
            iss_next   = wrap_inc(hand);
            evl_next   = hand;
            step_next  = '0;
            pass_next  = '0;
          end
        end else begin
          widx_next = widx + 1'b1;
          fm_raddr  = widx + 1'b1;
        end
      end
      S_SWEEP: begin
        attr_raddr = iss;
        iss_next   = wrap_inc(iss);
        evl_next   = iss;
        if (sw_victim) begin
          attr_we                  = 1'b1;
          attr_wdata               = fresh;
          res_next.frame_out       = FRAME_W'(evl);
          res_next.evicted         = 1'b1;
          res_next.writeback_valid = 1'b1;
          res_next.writeback       = lv.wb;
          res_next.page_modified   = lv.modified;
          hand_next                = wrap_inc(evl);
        end else begin
          if (sw_live) begin
            // second chance: drop the accessed bit and move on
            attr_we         = 1'b1;
            attr_wdata      = attr_rd;
            attr_wdata.refd = 1'b0;
          end
          if (sw_wrap) begin
            step_next = '0;
            pass_next = pass_inc;
          end else begin
            step_next = step_cnt + 1'b1;
          end
          if (sw_end) res_next.status = ST_NO_VICTIM;
        end
      end
      S_DONE: begin
        res_push = out_free;
      end
      default: ;
    endcase
  end

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> pass_cnt < max_passes)
    else $error("sweep ran past the pass limit");

  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FREE |-> widx <= WIW'(NW - 1))
    else $error("free search ran past the last word");

  a_wb_quiet: assert property (@(posedge clk) disable iff (rst)
    res_push && !res.writeback_valid |-> res.writeback == WB_DISCARD && !res.page_modified)
    else $error("write-back fields set without a page leaving");

  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    res_push && res.evicted |-> res.status == ST_OK && res.writeback_valid)
    else $error("eviction reported without write-back or with bad status");

  a_idle_mem: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE || state == S_DONE |-> !attr_we && !fm_cmd.wr)
    else $error("memory written between transactions");

endmodule

// ===== design/second_chance_frame_replacer.sv =====
// ---------------------------------------------------------------------------
// second_chance_frame_replacer - clock (second-chance) frame replacer
// Reference, pin, unpin and release read the target's attributes, update them and
// then present the result; allocate searches the free map word by word for a free
// frame and, with none found, sweeps the frames from the clock hand for a victim.
// One transaction in flight at a time; the next is taken while the result waits in
// the output register. After reset a clearing pass over every frame wipes the
// attribute memory and the free map.
// ---------------------------------------------------------------------------
module second_chance_frame_replacer
  import scfr_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,       // max_passes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // frame[5:0], is_write, from_file,
                                       // is_mmapped, modified_before, zeros
  input  logic [2:0]  s_axis_tuser,    // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // frame_out[5:0], evicted, status[1:0],
                                       // writeback_valid, writeback[1:0],
                                       // page_modified, zeros
);

  logic [3:0] max_passes;
  item_t      in_item;
  logic       out_free;
  logic       res_push;
  res_t       res;
  res_t       out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_passes <= MAX_PASSES_RST;
    end else if (cfg_we) begin
      max_passes <= cfg_wdata;
    end
  end

  assign in_item = '{op:       s_axis_tuser,
                     frame:    s_axis_tdata[5:0],
                     is_write: s_axis_tdata[6],
                     origin:   s_axis_tdata[9:7]};

  assign out_free = !m_axis_tvalid || m_axis_tready;

  scfr_ctrl #(.NUM_FRAMES(NUM_FRAMES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .max_passes (max_passes),
    .in_valid   (s_axis_tvalid),
    .in_item    (in_item),
    .in_ready   (s_axis_tready),
    .out_free   (out_free),
    .res_push   (res_push),
    .res        (res)
  );

  // output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {3'b000, out_res};

endmodule

// ===== tb/sv/second_chance_frame_replacer_test.sv =====
// ---------------------------------------------------------------------------
// second_chance_frame_replacer_test - self-checking bench for the replacer
// Drives allocate, reference, pin, unpin and release requests over the slave
// stream and checks every response on the master stream against a local
// model of the frame pool and clock hand. The pass limit is changed only
// while the block is idle. Both stream sides idle at random; a long receiver
// hold-off fills the block and stalls its input.
// ---------------------------------------------------------------------------
module second_chance_frame_replacer_test;
  import scfr_pkg::*;

  localparam int NF          = NUM_FRAMES_DEF;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int TAIL_CYCLES = 100;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  // local copy of the frame pool
  logic [NF-1:0] resident;
  logic [NF-1:0] pinned;
  logic [NF-1:0] accessed;
  logic [NF-1:0] dirty;
  logic [2:0]    origin_of [NF];
  int            hand;
  logic [3:0]    pass_limit;

  res_t expected_responses [$];
  int   mismatch_count;
  int   cycle_count;
  int   hold_cycles;
  bit   tx_burst;
  bit   rx_burst;

  second_chance_frame_replacer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- frame pool model ----------------------------------------------------

  function automatic res_t add_writeback(input res_t r, input int f);
    res_t o;
    logic modified;
    o = r;
    modified = dirty[f] | origin_of[f][ORG_MOD];
    o.writeback_valid = 1'b1;
    o.page_modified   = modified;
    if (origin_of[f][ORG_LOADED] && !modified) begin
      o.writeback = WB_DISCARD;
    end else if (origin_of[f][ORG_MMAP]) begin
      o.writeback = dirty[f] ? WB_FILE : WB_DISCARD;
    end else begin
      o.writeback = WB_SWAP;
    end
    return o;
  endfunction

  function automatic void place_page(input int f, input logic [2:0] org);
    resident[f]  = 1'b1;
    pinned[f]    = 1'b0;
    accessed[f]  = 1'b0;
    dirty[f]     = 1'b0;
    origin_of[f] = org;
  endfunction

  function automatic res_t resolve_request(input item_t req);
    res_t r;
    bit   granted;
    int   visits;
    int   cur;
    int   pos;
    r       = '0;
    granted = 1'b0;
    if (req.op == OP_ALLOC) begin
      for (int f = 0; f < NF && !granted; f++) begin
        if (!resident[f]) begin
          place_page(f, req.origin);
          r.frame_out = f[FRAME_W-1:0];
          granted     = 1'b1;
        end
      end
      if (!granted) begin
        visits = int'(pass_limit) * NF;
        pos    = hand;
        for (int n = 0; n < visits && !granted; n++) begin
          cur = pos;
          pos = (pos + 1) % NF;
          if (resident[cur] && !pinned[cur]) begin
            if (accessed[cur]) begin
              accessed[cur] = 1'b0;
            end else begin
              r = add_writeback(r, cur);
              place_page(cur, req.origin);
              r.frame_out = cur[FRAME_W-1:0];
              r.evicted   = 1'b1;
              granted     = 1'b1;
            end
          end
        end
        hand = pos;
        if (!granted) r.status = ST_NO_VICTIM;
      end
    end else if (req.op <= OP_RELEASE) begin
      r.frame_out = req.frame;
      if (!resident[req.frame]) begin
        r.status = ST_BAD_FRAME;
      end else begin
        case (req.op)
          OP_REF: begin
            accessed[req.frame] = 1'b1;
            if (req.is_write) dirty[req.frame] = 1'b1;
          end
          OP_PIN:   pinned[req.frame] = 1'b1;
          OP_UNPIN: pinned[req.frame] = 1'b0;
          default: begin
            r = add_writeback(r, req.frame);
            resident[req.frame]  = 1'b0;
            pinned[req.frame]    = 1'b0;
            accessed[req.frame]  = 1'b0;
            dirty[req.frame]     = 1'b0;
            origin_of[req.frame] = '0;
          end
        endcase
      end
    end
    return r;
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t request(input logic [2:0] op, input int frame,
                                    input logic wr, input logic [2:0] org);
    item_t q;
    q.op       = op;
    q.frame    = frame[FRAME_W-1:0];
    q.is_write = wr;
    q.origin   = org;
    return q;
  endfunction

  function automatic item_t random_fields(input logic [2:0] op);
    return request(op, $urandom_range(0, NF-1), 1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)));
  endfunction

  // resident frame near a random start, or the start itself if none
  function automatic int resident_frame();
    int  start;
    int  f;
    bit  found;
    start = $urandom_range(0, NF-1);
    f     = start;
    found = 1'b0;
    for (int k = 0; k < NF && !found; k++) begin
      if (resident[(start + k) % NF]) begin
        f     = (start + k) % NF;
        found = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic item_t random_request();
    item_t q;
    int    sel;
    sel = $urandom_range(0, 99);
    if (sel < 34)      q = random_fields(OP_ALLOC);
    else if (sel < 64) q = random_fields(OP_REF);
    else if (sel < 74) q = random_fields(OP_PIN);
    else if (sel < 86) q = random_fields(OP_UNPIN);
    else if (sel < 96) q = random_fields(OP_RELEASE);
    else               q = random_fields(3'($urandom_range(5, 7)));
    // aim most targeted requests at a resident frame
    if (sel >= 34 && sel < 96 && $urandom_range(0, 9) != 0) begin
      q.frame = FRAME_W'(resident_frame());
    end
    return q;
  endfunction

  task automatic issue_request(input item_t req);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tdata  <= {6'd0, req.origin, req.is_write, req.frame};
    s_axis_tuser  <= req.op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_responses.push_back(resolve_request(req));
  endtask

  task automatic wait_responses_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(negedge clk);
  endtask

  task automatic set_pass_limit(input logic [3:0] value);
    wait_responses_drained();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pass_limit = value;
  endtask

  // ---- tests ---------------------------------------------------------------

  task automatic test_empty_pool();
    issue_request(request(OP_REF, 0, 1'b1, 3'd0));
    issue_request(request(OP_PIN, NF-1, 1'b0, 3'd7));
    issue_request(request(OP_UNPIN, 21, 1'b1, 3'd2));
    issue_request(request(OP_RELEASE, 42, 1'b0, 3'd5));
    // undefined operations leave the pool untouched
    issue_request(request(3'd5, NF-1, 1'b1, 3'd7));
    issue_request(request(3'd6, 0, 1'b0, 3'd0));
    issue_request(request(3'd7, 33, 1'b1, 3'd4));
  endtask

  task automatic test_page_lifecycle();
    issue_request(request(OP_ALLOC, 0, 1'b0, 3'b001));  // loaded, clean
    issue_request(request(OP_ALLOC, NF-1, 1'b1, 3'b010)); // mapped file
    issue_request(request(OP_ALLOC, 0, 1'b0, 3'b110));  // mapped, modified before
    issue_request(request(OP_ALLOC, 0, 1'b0, 3'b000));  // anonymous
    issue_request(request(OP_ALLOC, 0, 1'b0, 3'b101));  // loaded, modified before
    issue_request(request(OP_REF, 1, 1'b1, 3'd0));
    issue_request(request(OP_REF, 2, 1'b0, 3'd0));
    issue_request(request(OP_REF, 0, 1'b0, 3'd0));
    // pinning is a flag: two pins are undone by one unpin
    issue_request(request(OP_PIN, 3, 1'b0, 3'd0));
    issue_request(request(OP_PIN, 3, 1'b0, 3'd0));
    issue_request(request(OP_UNPIN, 3, 1'b0, 3'd0));
    issue_request(request(OP_PIN, 4, 1'b0, 3'd0));
    issue_request(request(OP_RELEASE, 4, 1'b0, 3'd0));
    for (int f = 0; f < 4; f++) issue_request(request(OP_RELEASE, f, 1'b0, 3'd0));
    issue_request(request(OP_RELEASE, 2, 1'b0, 3'd0));
    issue_request(request(OP_ALLOC, 9, 1'b1, 3'b011));
  endtask

  task automatic test_clock_sweep();
    while (resident != '1) issue_request(random_fields(OP_ALLOC));
    for (int f = 0; f < NF; f++) issue_request(request(OP_PIN, f, 1'b0, 3'd0));
    // every frame pinned: no victim at the shortest nonzero, zero and longest limits
    set_pass_limit(4'd1);
    issue_request(random_fields(OP_ALLOC));
    set_pass_limit(4'd0);
    issue_request(random_fields(OP_ALLOC));
    set_pass_limit(4'd15);
    issue_request(random_fields(OP_ALLOC));
    for (int f = 0; f < NF; f++) issue_request(request(OP_UNPIN, f, 1'b0, 3'd0));
    for (int f = 0; f < NF; f++) begin
      issue_request(request(OP_REF, f, 1'($urandom_range(0, 1)), 3'd0));
    end
    // first sweep clears every accessed flag, the next frame is the victim
    for (int k = 0; k < 4; k++) issue_request(random_fields(OP_ALLOC));
    issue_request(request(OP_REF, resident_frame(), 1'b1, 3'd0));
    for (int k = 0; k < 4; k++) issue_request(random_fields(OP_ALLOC));
  endtask

  task automatic test_backpressure();
    wait_responses_drained();
    hold_cycles = 150;
    tx_burst    = 1'b1;
    for (int k = 0; k < 12; k++) issue_request(random_request());
    tx_burst = 1'b0;
    wait_responses_drained();
  endtask

  task automatic test_random_traffic();
    logic [3:0] limits [5];
    limits[0] = 4'd15;
    limits[1] = 4'd1;
    limits[2] = 4'($urandom_range(2, 14));
    limits[3] = MAX_PASSES_RST;
    limits[4] = 4'($urandom_range(1, 15));
    for (int p = 0; p < 5; p++) begin
      set_pass_limit(limits[p]);
      tx_burst = (p == 2);
      rx_burst = (p == 2);
      for (int k = 0; k < 310; k++) issue_request(random_request());
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // ---- receiver, checker, watchdog -----------------------------------------

  initial begin
    int rx_stall;
    rx_stall      = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else if (rx_burst || $urandom_range(0, 99) >= 25) begin
        m_axis_tready <= 1'b1;
      end else begin
        rx_stall = pick_gap();
        m_axis_tready <= (rx_stall == 0);
      end
    end
  end

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(res_t)-1:0];
      if (expected_responses.size() == 0) begin
        $error("response with no request outstanding: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_responses.pop_front();
        compare_field("frame_out", want.frame_out, got.frame_out);
        compare_field("evicted", want.evicted, got.evicted);
        compare_field("status", want.status, got.status);
        compare_field("writeback_valid", want.writeback_valid, got.writeback_valid);
        compare_field("writeback", want.writeback, got.writeback);
        compare_field("page_modified", want.page_modified, got.page_modified);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---- sequence ------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    resident       = '0;
    pinned         = '0;
    accessed       = '0;
    dirty          = '0;
    for (int f = 0; f < NF; f++) origin_of[f] = '0;
    hand           = 0;
    pass_limit     = MAX_PASSES_RST;
    mismatch_count = 0;
    hold_cycles    = 0;
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pool();
    test_page_lifecycle();
    test_clock_sweep();
    test_backpressure();
    test_random_traffic();

    wait_responses_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $error("%0d responses never arrived", expected_responses.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/scfr_pkg.sv
design/scfr_free_map.sv
design/scfr_ctrl.sv
design/second_chance_frame_replacer.sv
tb/sv/second_chance_frame_replacer_test.sv
